FILE: rtl/wrqp_pkg.sv
// ----------------------------------------------------------------------------
// wrqp_pkg
// Shared types and constants of the weighted random queue picker: payload
// structs of the request and response channels, field widths and the
// configuration register map.
// ----------------------------------------------------------------------------
package wrqp_pkg;

    // Field widths
    localparam int MASK_W      = 4;
    localparam int RANDOM_BITS = 16;
    localparam int WEIGHT_W    = 8;
    localparam int QUEUE_W     = 2;
    localparam int CFG_INDEX_W = 8;

    // Default queue count, handed to the top level
    localparam int NUM_QUEUES_DEF = 4;

    // Weight after reset
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1);

    // Configuration register map
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_Q0 = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_Q1 = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_Q2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_Q3 = CFG_INDEX_W'(3);

    // Request payload
    typedef struct packed {
        logic [MASK_W-1:0]      nonempty_mask;
        logic [RANDOM_BITS-1:0] random_fraction;
    } req_t;

    // Response payload
    typedef struct packed {
        logic               grant_valid;
        logic [QUEUE_W-1:0] grant_queue;
    } rsp_t;

endpackage

FILE: rtl/wrqp_pick.sv
// ----------------------------------------------------------------------------
// wrqp_pick
// Lottery selection: sums the weights of the non-empty queues, scales the
// random fraction by that total and finds the queue whose weight interval
// holds the scaled value.
// ----------------------------------------------------------------------------
module wrqp_pick #(
    parameter int NUM_QUEUES = wrqp_pkg::NUM_QUEUES_DEF
) (
    input  logic [NUM_QUEUES-1:0][wrqp_pkg::WEIGHT_W-1:0] weights,
    input  wrqp_pkg::req_t                                 req,
    output wrqp_pkg::rsp_t                                 rsp
);

    localparam int TOTAL_W = wrqp_pkg::WEIGHT_W + $clog2(NUM_QUEUES);
    localparam int PROD_W  = TOTAL_W + wrqp_pkg::RANDOM_BITS;

    logic [NUM_QUEUES-1:0][TOTAL_W-1:0] edge_sum;
    logic [TOTAL_W-1:0]                 total;
    logic [PROD_W-1:0]                  product;
    logic [TOTAL_W-1:0]                 scaled;

    // Running sums of the weights of non-empty queues, in index order
    always_comb
    begin
        logic [TOTAL_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if (req.nonempty_mask[i])
            begin
                acc = acc + TOTAL_W'(weights[i]);
            end
            edge_sum[i] = acc;
        end
    end

    assign total   = edge_sum[NUM_QUEUES-1];
    assign product = PROD_W'(total) * PROD_W'(req.random_fraction);
    assign scaled  = product[PROD_W-1:wrqp_pkg::RANDOM_BITS];

    // First non-empty queue whose upper edge lies above the scaled value.
    // An empty total gives scaled zero and no hit.
    always_comb
    begin
        rsp.grant_valid = 1'b0;
        rsp.grant_queue = '0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if (!rsp.grant_valid && req.nonempty_mask[i] && (scaled < edge_sum[i]))
            begin
                rsp.grant_valid = 1'b1;
                rsp.grant_queue = wrqp_pkg::QUEUE_W'(i);
            end
        end
    end

endmodule

FILE: rtl/weighted_random_queue_picker_core.sv
// ----------------------------------------------------------------------------
// weighted_random_queue_picker_core
// Lottery scheduler: grants one of the non-empty queues with probability in
// proportion to its programmed weight.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel  - cfg_index selects a weight register (0..3 for queues
//                  0..3), cfg_data is the new weight. cfg_ready is always
//                  high; writes to an index past the queue count are dropped.
//                  Write weights only while no request is in flight.
//   req channel  - one transfer per decision: non-empty mask and a uniform
//                  random fraction.
//   rsp channel  - one transfer per request, in order: grant_valid and the
//                  granted queue (queue 0 with grant_valid low when no queue
//                  is non-empty or all their weights are zero).
// A request transfer loads the request register; the weight sum, the
// multiply by the fraction and the interval compare then settle into the
// response register, which raises rsp_valid once it loads.
// Throughput is one request per cycle while rsp_ready stays high.
// When the receiver stalls, the response register holds and the request
// register fills; req_ready then drops until rsp_ready returns.
// Reset empties both registers and sets every weight to 1.
// ----------------------------------------------------------------------------
module weighted_random_queue_picker_core #(
    parameter int NUM_QUEUES = wrqp_pkg::NUM_QUEUES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wrqp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wrqp_pkg::WEIGHT_W-1:0]    cfg_data,

    input  logic                             req_valid,
    output logic                             req_ready,
    input  wrqp_pkg::req_t                   req_data,

    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output wrqp_pkg::rsp_t                   rsp_data
);

    logic [NUM_QUEUES-1:0][wrqp_pkg::WEIGHT_W-1:0] weight_reg;

    logic           s1_valid_reg;
    wrqp_pkg::req_t s1_req_reg;
    logic           rsp_valid_reg;
    wrqp_pkg::rsp_t rsp_reg;
    wrqp_pkg::rsp_t rsp_next;
    logic           rsp_load;

    // Weight registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                weight_reg[i] <= wrqp_pkg::WEIGHT_RESET;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                if (cfg_index == (wrqp_pkg::REG_WEIGHT_Q0 + wrqp_pkg::CFG_INDEX_W'(i)))
                begin
                    weight_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Pipeline control: response register loads when it is free or drained
    assign rsp_load  = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || rsp_load;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg <= req_data;
        end
    end

    // Lottery selection
    wrqp_pick #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_pick (
        .weights (weight_reg),
        .req     (s1_req_reg),
        .rsp     (rsp_next)
    );

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef SYNTHESIS
    // A response without a grant carries queue zero
    a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.grant_valid |-> rsp_reg.grant_queue == '0)
        else $error("response without grant carries a non-zero queue");

    // A granted queue exists
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.grant_valid
            |-> 32'(rsp_reg.grant_queue) < NUM_QUEUES)
        else $error("granted queue beyond queue count");

    // A waiting request is neither lost nor overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !rsp_load |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("stalled request lost or changed");

    // A loaded response is offered next cycle
    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> rsp_valid_reg)
        else $error("loaded response not offered");
`endif

endmodule

FILE: tb/wrqp_grant_checker.sv
// ----------------------------------------------------------------------------
// wrqp_grant_checker
// Watches the configuration, request and response channels of the weighted
// random queue picker. It keeps its own copy of the weight registers and
// works out the expected grant for each request transfer. Each response
// transfer is compared field by field with the oldest expected grant. The
// failure count and the number of grants still due go back to the top.
// ----------------------------------------------------------------------------
module wrqp_grant_checker #(
    parameter int NUM_QUEUES = wrqp_pkg::NUM_QUEUES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [wrqp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wrqp_pkg::WEIGHT_W-1:0]    cfg_data,
    input  logic                             req_valid,
    input  logic                             req_ready,
    input  wrqp_pkg::req_t                   req_data,
    input  logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  wrqp_pkg::rsp_t                   rsp_data,
    output int                               fail_count,
    output int                               grants_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [wrqp_pkg::WEIGHT_W-1:0] weight_copy [NUM_QUEUES];
    wrqp_pkg::rsp_t                grants_due [$];

    // Lottery draw: scale the fraction by the summed weights of the non-empty
    // queues, then walk the weight intervals in increasing queue order
    function automatic wrqp_pkg::rsp_t lottery_grant(wrqp_pkg::req_t r);
        logic [9:0]     total;
        logic [9:0]     bound;
        logic [25:0]    product;
        logic [9:0]     scaled;
        wrqp_pkg::rsp_t g;
        total = '0;
        bound = '0;
        g     = '0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if (r.nonempty_mask[q])
                total += weight_copy[q];
        end
        product = total * r.random_fraction;
        scaled  = product[25:wrqp_pkg::RANDOM_BITS];
        if (total != '0)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                if (r.nonempty_mask[q])
                begin
                    bound += weight_copy[q];
                    if (!g.grant_valid && scaled < bound)
                    begin
                        g.grant_valid = 1'b1;
                        g.grant_queue = wrqp_pkg::QUEUE_W'(q);
                    end
                end
            end
        end
        return g;
    endfunction

    // Check responses, predict requests, then track register writes
    always @(posedge clk or negedge rst_n)
    begin
        wrqp_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
                weight_copy[q] = wrqp_pkg::WEIGHT_RESET;
            grants_due.delete();
            grants_pending = 0;
            fail_count     = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (grants_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: response transfer with no grant due: valid=%0b queue=%0d",
                                 $realtime, rsp_data.grant_valid, rsp_data.grant_queue);
                    fail_count++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    grants_pending--;
                    if (rsp_data.grant_valid !== want.grant_valid ||
                        rsp_data.grant_queue !== want.grant_queue)
                    begin
                        if (fail_count < 10)
                            $display("%0t: grant mismatch: exp %0b/%0d, got %0b/%0d",
                                     $realtime, want.grant_valid, want.grant_queue,
                                     rsp_data.grant_valid, rsp_data.grant_queue);
                        fail_count++;
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                grants_due = {grants_due, lottery_grant(req_data)};
                grants_pending++;
            end

            // writes past the last weight register are dropped
            if (cfg_valid && cfg_ready && cfg_index <= wrqp_pkg::REG_WEIGHT_Q3 &&
                int'(cfg_index) < NUM_QUEUES)
                weight_copy[cfg_index[wrqp_pkg::QUEUE_W-1:0]] = cfg_data;
        end
    end

endmodule

FILE: tb/weighted_random_queue_picker_core_tb.sv
// ----------------------------------------------------------------------------
// weighted_random_queue_picker_core_tb
// Drives the weighted random queue picker with directed requests around the
// weight and fraction extremes, zero weights and ignored register writes,
// then with random requests under several weight settings. Both sides idle
// at random; one stretch runs flat out and one holds the receiver off long
// enough to stall the request side. The checker beside the block predicts
// and compares every grant.
// ----------------------------------------------------------------------------
module weighted_random_queue_picker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that map to no weight
    localparam logic [wrqp_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LO =
        wrqp_pkg::CFG_INDEX_W'(4);
    localparam logic [wrqp_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HI = '1;

    localparam int PHASE_ITEMS = 135;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [wrqp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wrqp_pkg::WEIGHT_W-1:0]    cfg_data;
    logic                             req_valid;
    logic                             req_ready;
    wrqp_pkg::req_t                   req_data;
    logic                             rsp_valid;
    logic                             rsp_ready;
    wrqp_pkg::rsp_t                   rsp_data;

    int fail_count;
    int grants_pending;
    bit idle_on;
    bit long_hold_go;

    weighted_random_queue_picker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    wrqp_grant_checker grant_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data),
        .fail_count     (fail_count),
        .grants_pending (grants_pending)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_go && !hold_done)
            begin
                hold_left = 80;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else if (idle_on)
                rsp_ready <= ($urandom_range(99) >= 27);
            else
                rsp_ready <= 1'b1;
        end
    end

    // One request transfer, with an occasional gap before it
    task automatic offer_request(input logic [wrqp_pkg::MASK_W-1:0] mask,
                                 input logic [wrqp_pkg::RANDOM_BITS-1:0] frac);
        if (idle_on && $urandom_range(99) < 27)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
        @(negedge clk);
        req_valid                <= 1'b1;
        req_data.nonempty_mask   <= mask;
        req_data.random_fraction <= frac;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stop offering and let every due grant come back
    task automatic wait_for_grants();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (grants_pending == 0);
        repeat (4) @(posedge clk);
    endtask

    // One register write transfer; valid is left high for a following write
    task automatic write_reg(input logic [wrqp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [wrqp_pkg::WEIGHT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Reprogram all four weights once the block has gone idle
    task automatic set_weights(input logic [wrqp_pkg::WEIGHT_W-1:0] w0,
                               input logic [wrqp_pkg::WEIGHT_W-1:0] w1,
                               input logic [wrqp_pkg::WEIGHT_W-1:0] w2,
                               input logic [wrqp_pkg::WEIGHT_W-1:0] w3);
        wait_for_grants();
        write_reg(wrqp_pkg::REG_WEIGHT_Q0, w0);
        write_reg(wrqp_pkg::REG_WEIGHT_Q1, w1);
        write_reg(wrqp_pkg::REG_WEIGHT_Q2, w2);
        write_reg(wrqp_pkg::REG_WEIGHT_Q3, w3);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [wrqp_pkg::WEIGHT_W-1:0] pick_weight(input bit allow_zero);
        int roll;
        roll = $urandom_range(99);
        if (allow_zero && roll < 12)
            return '0;
        else if (roll < 25)
            return '1;
        else if (roll < 35)
            return wrqp_pkg::WEIGHT_W'(1);
        else
            return wrqp_pkg::WEIGHT_W'($urandom_range(255, 1));
    endfunction

    // Stimulus and verdict
    initial
    begin
        logic [wrqp_pkg::MASK_W-1:0]      mask;
        logic [wrqp_pkg::RANDOM_BITS-1:0] frac;
        int                               roll;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_valid    = 1'b0;
        req_data     = '0;
        idle_on      = 1;
        long_hold_go = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset weights: nothing pending, full spread, top and middle fractions
        offer_request(4'h0, 16'hFFFF);
        offer_request(4'hF, 16'h0000);
        offer_request(4'hF, 16'hFFFF);
        offer_request(4'h1, 16'h8000);
        offer_request(4'h8, 16'hC000);

        // largest weights everywhere
        set_weights(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        offer_request(4'hF, 16'hFFFF);
        offer_request(4'h8, 16'h0000);
        offer_request(4'h6, 16'h7FFF);

        // zero weights: empty intervals, and no grant when all weights are zero
        set_weights(8'h00, 8'h01, 8'h00, 8'hFF);
        offer_request(4'h5, 16'hFFFF);
        offer_request(4'hF, 16'h0000);
        offer_request(4'hF, 16'h0100);
        offer_request(4'hA, 16'hFFFF);
        offer_request(4'h2, 16'hFFFF);
        offer_request(4'h1, 16'h1234);

        // writes past the register map leave the weights alone
        wait_for_grants();
        write_reg(REG_UNMAPPED_LO, 8'h77);
        write_reg(REG_UNMAPPED_HI, 8'h00);
        @(negedge clk);
        cfg_valid <= 1'b0;
        offer_request(4'hF, 16'h0000);
        offer_request(4'hF, 16'h00FF);

        // uneven weights at the interval boundaries
        set_weights(8'h01, 8'hFF, 8'h01, 8'hFF);
        offer_request(4'hF, 16'h0101);
        offer_request(4'hF, 16'h8000);
        offer_request(4'hF, 16'hFFFF);

        // random phases under several weight settings
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:       set_weights(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                3:       set_weights(8'h01, 8'h01, 8'h01, 8'h01);
                4:       set_weights(pick_weight(1), pick_weight(1),
                                     pick_weight(1), pick_weight(1));
                default: set_weights(pick_weight(0), pick_weight(0),
                                     pick_weight(0), pick_weight(0));
            endcase
            idle_on = (phase != 2);
            if (phase == 1)
                long_hold_go = 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                mask = (roll < 8) ? '0 : wrqp_pkg::MASK_W'($urandom_range(15, 1));
                roll = $urandom_range(99);
                if (roll < 8)
                    frac = '0;
                else if (roll < 16)
                    frac = '1;
                else
                    frac = wrqp_pkg::RANDOM_BITS'($urandom);
                offer_request(mask, frac);
            end
        end

        wait_for_grants();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && grants_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
